FILE: design/ecl_pkg.sv
// Shared types and constants for the polygon ear-clip triangulator.
`default_nettype none

package ecl_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int THR_W        = 16;
    localparam int MIN_POLY     = 3;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int ATT_W        = CNT_W + 1;
    localparam int DIF_W        = COORD_BITS + 1;
    localparam int PRD_W        = 2 * DIF_W;
    localparam int XP_W         = PRD_W + 1;
    localparam int ACC_W        = XP_W + IDX_W + 1;
    localparam int S_TDATA_W    = 2 * COORD_BITS;
    localparam int M_TRI_W      = 3 * IDX_W;
    localparam int M_TDATA_W    = ((M_TRI_W + 7) / 8) * 8;
    localparam int M_TUSER_W    = 3;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SHORT,
        ST_AREA, ST_AREA_P, ST_AREA_X, ST_AREA_W,
        ST_INIT, ST_PASS,
        ST_CAND, ST_CAND_B, ST_CAND_C, ST_CONV, ST_CONV_W, ST_NEXT,
        ST_TEST, ST_T1, ST_T1_W, ST_T2, ST_T2_W, ST_T3, ST_T3_W, ST_TCHK,
        ST_EAR, ST_MOVE, ST_MOVE_W,
        ST_END, ST_END_B, ST_END_C, ST_END_P,
        ST_FIN, ST_FAN, ST_FLUSH,
        ST_F_REM, ST_F_CRD, ST_F_CAP
    } t_state;

    // Operand slot that a fetched vertex lands in
    typedef enum logic [1:0] {SLOT_A, SLOT_B, SLOT_C, SLOT_P} t_slot;

    // Operand selection of the cross-product unit
    typedef enum logic [2:0] {XM_AREA, XM_CONV, XM_T1, XM_T2, XM_T3} t_xmode;

    typedef struct packed {
        logic             ovf;
        logic             fb;
        logic             has;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] a;
    } t_tri;

    typedef struct packed {
        logic             ld_we;
        logic [IDX_W-1:0] ld_addr;
        logic             crd_via_rem;
        logic [IDX_W-1:0] crd_addr;
        logic [IDX_W-1:0] rem_raddr;
        logic             rem_we;
        logic [IDX_W-1:0] rem_waddr;
        logic             rem_wsel_rd;
        logic [IDX_W-1:0] rem_wdata;
        logic             cap;
        t_slot            cap_slot;
        logic             xp_start;
        t_xmode           xp_mode;
        logic             acc_clr;
        logic             acc_add;
        logic             flg_clr;
        logic             flg_upd;
        logic             produce;
        logic             prod_imm;
        t_tri             tri_imm;
        logic             ovf;
        logic             flush;
    } t_cmd;

    typedef struct packed {
        logic prod_ok;
        logic out_free;
        logic pend_valid;
        logic xp_done;
        logic conv_ok;
        logic in_tri;
        logic area_neg;
    } t_sts;

endpackage

`default_nettype wire

FILE: design/ecl_cross.sv
// Three-stage 2D cross-product unit: (b - a) x (p - a).
`default_nettype none

module ecl_cross (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_ax,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_ay,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_bx,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_by,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_px,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_py,
    output logic                                     o_valid,
    output logic signed [ecl_pkg::XP_W-1:0]          o_res
);
    import ecl_pkg::*;

    logic                    r_v1, r_v2, r_v3;
    logic signed [DIF_W-1:0] r_d1x, r_d1y, r_d2x, r_d2y;
    logic signed [PRD_W-1:0] r_m1, r_m2;
    logic signed [XP_W-1:0]  r_res;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // edge differences, products, final subtract
    always_ff @(posedge i_clk) begin
        r_d1x <= DIF_W'(i_bx) - DIF_W'(i_ax);
        r_d1y <= DIF_W'(i_by) - DIF_W'(i_ay);
        r_d2x <= DIF_W'(i_px) - DIF_W'(i_ax);
        r_d2y <= DIF_W'(i_py) - DIF_W'(i_ay);
        r_m1  <= r_d1x * r_d2y;
        r_m2  <= r_d2x * r_d1y;
        r_res <= XP_W'(r_m1) - XP_W'(r_m2);
    end

    assign o_valid = r_v3;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: design/ecl_datapath.sv
// Datapath: vertex and index stores, operand slots, cross unit, result registers.
`default_nettype none

module ecl_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire ecl_pkg::t_cmd                         i_cmd,
    output ecl_pkg::t_sts                              o_sts,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_vx,
    input  wire logic signed [ecl_pkg::COORD_BITS-1:0] i_vy,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ecl_pkg::THR_W-1:0]             i_cfg_wdata,
    output logic                                       o_m_valid,
    input  wire logic                                  i_m_ready,
    output ecl_pkg::t_tri                              o_m_tri,
    output logic                                       o_m_last
);
    import ecl_pkg::*;

    logic signed [COORD_BITS-1:0] r_mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_mem_y [MAX_VERTICES];
    logic [IDX_W-1:0]             r_mem_rem [MAX_VERTICES];

    logic signed [COORD_BITS-1:0] r_rdx, r_rdy;
    logic [IDX_W-1:0]             r_cidx, r_rem_rd;
    logic [IDX_W-1:0]             w_caddr;

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_px, r_py;
    logic [IDX_W-1:0]             r_ia, r_ib, r_ic;

    logic signed [COORD_BITS-1:0] w_oax, w_oay, w_obx, w_oby, w_opx, w_opy;
    logic                         w_xp_done;
    logic signed [XP_W-1:0]       w_xp_res;

    logic signed [ACC_W-1:0]      r_acc;
    logic                         r_fneg, r_fpos;
    logic [THR_W-1:0]             r_thr;
    logic [XP_W-1:0]              w_thr_ext;

    logic                         r_ovalid, r_pvalid, r_olast;
    t_tri                         r_out, r_pend, w_new;
    logic                         w_out_free;

    // vertex store: written on load, one registered read port
    assign w_caddr = i_cmd.crd_via_rem ? r_rem_rd : i_cmd.crd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_we) begin
            r_mem_x[i_cmd.ld_addr] <= i_vx;
            r_mem_y[i_cmd.ld_addr] <= i_vy;
        end
        r_rdx  <= r_mem_x[w_caddr];
        r_rdy  <= r_mem_y[w_caddr];
        r_cidx <= w_caddr;
    end

    // remaining-vertex list
    always_ff @(posedge i_clk) begin
        if (i_cmd.rem_we) begin
            r_mem_rem[i_cmd.rem_waddr] <= i_cmd.rem_wsel_rd ? r_rem_rd : i_cmd.rem_wdata;
        end
        r_rem_rd <= r_mem_rem[i_cmd.rem_raddr];
    end

    // operand slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            case (i_cmd.cap_slot)
                SLOT_A: begin
                    r_ax <= r_rdx; r_ay <= r_rdy; r_ia <= r_cidx;
                end
                SLOT_B: begin
                    r_bx <= r_rdx; r_by <= r_rdy; r_ib <= r_cidx;
                end
                SLOT_C: begin
                    r_cx <= r_rdx; r_cy <= r_rdy; r_ic <= r_cidx;
                end
                default: begin
                    r_px <= r_rdx; r_py <= r_rdy;
                end
            endcase
        end
    end

    // cross-unit operand select
    always_comb begin
        w_oax = '0; w_oay = '0;
        w_obx = r_bx; w_oby = r_by;
        w_opx = r_px; w_opy = r_py;
        case (i_cmd.xp_mode)
            XM_CONV: begin
                w_oax = r_ax; w_oay = r_ay; w_opx = r_cx; w_opy = r_cy;
            end
            XM_T1: begin
                w_oax = r_ax; w_oay = r_ay;
            end
            XM_T2: begin
                w_oax = r_bx; w_oay = r_by; w_obx = r_cx; w_oby = r_cy;
            end
            XM_T3: begin
                w_oax = r_cx; w_oay = r_cy; w_obx = r_ax; w_oby = r_ay;
            end
            default: begin
                w_oax = '0; w_oay = '0;
            end
        endcase
    end

    ecl_cross u_xp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.xp_start),
        .i_ax    (w_oax),
        .i_ay    (w_oay),
        .i_bx    (w_obx),
        .i_by    (w_oby),
        .i_px    (w_opx),
        .i_py    (w_opy),
        .o_valid (w_xp_done),
        .o_res   (w_xp_res)
    );

    // shoelace accumulator and point-in-triangle sign flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + {{(ACC_W-XP_W){w_xp_res[XP_W-1]}}, w_xp_res};
        end
        if (i_cmd.flg_clr) begin
            r_fneg <= 1'b0;
            r_fpos <= 1'b0;
        end else if (i_cmd.flg_upd) begin
            r_fneg <= r_fneg | w_xp_res[XP_W-1];
            r_fpos <= r_fpos | (!w_xp_res[XP_W-1] && (w_xp_res != '0));
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end
    assign w_thr_ext = {{(XP_W-THR_W){1'b0}}, r_thr};

    // pending result and output register
    assign w_out_free = !r_ovalid || i_m_ready;

    always_comb begin
        if (i_cmd.prod_imm) begin
            w_new = i_cmd.tri_imm;
        end else begin
            w_new     = '0;
            w_new.a   = r_ia;
            w_new.b   = r_ib;
            w_new.c   = r_ic;
            w_new.has = 1'b1;
        end
        w_new.ovf = i_cmd.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.produce) begin
                r_pvalid <= 1'b1;
                if (r_pvalid) begin
                    r_ovalid <= 1'b1;
                end
            end else if (i_cmd.flush) begin
                r_pvalid <= 1'b0;
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.produce) begin
            r_pend <= w_new;
            if (r_pvalid) begin
                r_out   <= r_pend;
                r_olast <= 1'b0;
            end
        end else if (i_cmd.flush) begin
            r_out   <= r_pend;
            r_olast <= 1'b1;
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_m_tri   = r_out;
    assign o_m_last  = r_olast;

    always_comb begin
        o_sts            = '0;
        o_sts.out_free   = w_out_free;
        o_sts.prod_ok    = !r_pvalid || w_out_free;
        o_sts.pend_valid = r_pvalid;
        o_sts.xp_done    = w_xp_done;
        o_sts.conv_ok    = $signed(w_xp_res) > $signed(w_thr_ext);
        o_sts.in_tri     = !(r_fneg && r_fpos);
        o_sts.area_neg   = r_acc[ACC_W-1];
    end

    a_prod_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.produce |-> (!r_pvalid || w_out_free))
        else $error("result produced with no room");
    a_flush_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_pvalid && w_out_free))
        else $error("flush without pending result or room");
    a_xp_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.xp_start |-> ##3 w_xp_done)
        else $error("cross unit latency broken");

endmodule

`default_nettype wire

FILE: design/ecl_ctrl.sv
// Controller: load, area, ear search, clipping, fallback and flush sequencing.
`default_nettype none

module ecl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_last,
    input  wire ecl_pkg::t_sts i_sts,
    output ecl_pkg::t_cmd      o_cmd
);
    import ecl_pkg::*;

    t_state           r_state, n_state, r_ret, n_ret;
    logic [CNT_W-1:0] r_vcnt, n_vcnt, r_cnt, n_cnt;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [ATT_W-1:0] r_att, n_att, w_att_dec;
    logic             r_ovf, n_ovf;
    logic [IDX_W-1:0] r_faddr, n_faddr;
    t_slot            r_slot, n_slot;
    logic             r_via, n_via;
    logic [CNT_W-1:0] w_ip, w_in, w_inext, w_vnew, w_aj;
    logic             w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_vcnt  <= '0;
            r_cnt   <= '0;
            r_att   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_faddr <= '0;
            r_slot  <= SLOT_A;
            r_via   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_vcnt  <= n_vcnt;
            r_cnt   <= n_cnt;
            r_att   <= n_att;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_faddr <= n_faddr;
            r_slot  <= n_slot;
            r_via   <= n_via;
        end
    end

    // ring neighbours of the current corner
    assign w_inext   = r_i + CNT_W'(1);
    assign w_ip      = (r_i == '0) ? (r_cnt - CNT_W'(1)) : (r_i - CNT_W'(1));
    assign w_in      = (w_inext == r_cnt) ? '0 : w_inext;
    assign w_aj      = (w_inext == r_vcnt) ? '0 : w_inext;
    assign w_full    = (r_vcnt == CNT_W'(MAX_VERTICES));
    assign w_vnew    = w_full ? r_vcnt : (r_vcnt + CNT_W'(1));
    assign w_att_dec = r_att - ATT_W'(1);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_vcnt  = r_vcnt;
        n_cnt   = r_cnt;
        n_att   = r_att;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_faddr = r_faddr;
        n_slot  = r_slot;
        n_via   = r_via;
        o_ready = 1'b0;

        o_cmd             = '0;
        o_cmd.ld_addr     = r_vcnt[IDX_W-1:0];
        o_cmd.crd_addr    = r_faddr;
        o_cmd.crd_via_rem = r_via;
        o_cmd.rem_raddr   = r_faddr;
        o_cmd.cap_slot    = r_slot;
        o_cmd.ovf         = r_ovf;
        o_cmd.xp_mode     = XM_AREA;

        case (r_state)
            // vertex load
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.ld_we = !w_full;
                    n_vcnt      = w_vnew;
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_i           = '0;
                        o_cmd.acc_clr = 1'b1;
                        n_state = (w_vnew < CNT_W'(MIN_POLY)) ? ST_SHORT : ST_AREA;
                    end
                end
            end
            ST_SHORT: begin
                o_cmd.produce  = i_sts.prod_ok;
                o_cmd.prod_imm = 1'b1;
                if (i_sts.prod_ok) begin
                    n_state = ST_FLUSH;
                end
            end
            // signed area, one edge term per pass
            ST_AREA: begin
                n_faddr = r_i[IDX_W-1:0]; n_slot = SLOT_B; n_via = 1'b0;
                n_ret = ST_AREA_P; n_state = ST_F_CRD;
            end
            ST_AREA_P: begin
                n_faddr = w_aj[IDX_W-1:0]; n_slot = SLOT_P; n_via = 1'b0;
                n_ret = ST_AREA_X; n_state = ST_F_CRD;
            end
            ST_AREA_X: begin
                o_cmd.xp_start = 1'b1;
                n_state        = ST_AREA_W;
            end
            ST_AREA_W: begin
                if (i_sts.xp_done) begin
                    o_cmd.acc_add = 1'b1;
                    if (w_inext == r_vcnt) begin
                        n_i     = '0;
                        n_state = ST_INIT;
                    end else begin
                        n_i     = w_inext;
                        n_state = ST_AREA;
                    end
                end
            end
            // index list, reversed for clockwise input
            ST_INIT: begin
                o_cmd.rem_we    = 1'b1;
                o_cmd.rem_waddr = r_i[IDX_W-1:0];
                o_cmd.rem_wdata = i_sts.area_neg ?
                                  IDX_W'(r_vcnt - CNT_W'(1) - r_i) : r_i[IDX_W-1:0];
                if (w_inext == r_vcnt) begin
                    n_cnt   = r_vcnt;
                    n_att   = {r_vcnt, 1'b0};
                    n_state = ST_PASS;
                end else begin
                    n_i = w_inext;
                end
            end
            ST_PASS: begin
                if (r_cnt > CNT_W'(MIN_POLY)) begin
                    n_att = w_att_dec;
                    if (w_att_dec == '0) begin
                        n_state = ST_END;
                    end else begin
                        n_i     = '0;
                        n_state = ST_CAND;
                    end
                end else begin
                    n_state = ST_END;
                end
            end
            // fetch the corner and its neighbours
            ST_CAND: begin
                n_faddr = w_ip[IDX_W-1:0]; n_slot = SLOT_A; n_via = 1'b1;
                n_ret = ST_CAND_B; n_state = ST_F_REM;
            end
            ST_CAND_B: begin
                n_faddr = r_i[IDX_W-1:0]; n_slot = SLOT_B; n_via = 1'b1;
                n_ret = ST_CAND_C; n_state = ST_F_REM;
            end
            ST_CAND_C: begin
                n_faddr = w_in[IDX_W-1:0]; n_slot = SLOT_C; n_via = 1'b1;
                n_ret = ST_CONV; n_state = ST_F_REM;
            end
            ST_CONV: begin
                o_cmd.xp_start = 1'b1;
                o_cmd.xp_mode  = XM_CONV;
                n_state        = ST_CONV_W;
            end
            ST_CONV_W: begin
                if (i_sts.xp_done) begin
                    if (i_sts.conv_ok) begin
                        n_j     = '0;
                        n_state = ST_TEST;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                if (w_inext == r_cnt) begin
                    n_state = ST_END;
                end else begin
                    n_i     = w_inext;
                    n_state = ST_CAND;
                end
            end
            // containment test against every remaining vertex other than the three corners
            ST_TEST: begin
                if (r_j == r_cnt) begin
                    n_state = ST_EAR;
                end else if (r_j == r_i || r_j == w_ip || r_j == w_in) begin
                    n_j = r_j + CNT_W'(1);
                end else begin
                    n_faddr = r_j[IDX_W-1:0]; n_slot = SLOT_P; n_via = 1'b1;
                    n_ret = ST_T1; n_state = ST_F_REM;
                end
            end
            ST_T1: begin
                o_cmd.xp_start = 1'b1;
                o_cmd.xp_mode  = XM_T1;
                o_cmd.flg_clr  = 1'b1;
                n_state        = ST_T1_W;
            end
            ST_T1_W: begin
                if (i_sts.xp_done) begin
                    o_cmd.flg_upd = 1'b1;
                    n_state       = ST_T2;
                end
            end
            ST_T2: begin
                o_cmd.xp_start = 1'b1;
                o_cmd.xp_mode  = XM_T2;
                n_state        = ST_T2_W;
            end
            ST_T2_W: begin
                if (i_sts.xp_done) begin
                    o_cmd.flg_upd = 1'b1;
                    n_state       = ST_T3;
                end
            end
            ST_T3: begin
                o_cmd.xp_start = 1'b1;
                o_cmd.xp_mode  = XM_T3;
                n_state        = ST_T3_W;
            end
            ST_T3_W: begin
                if (i_sts.xp_done) begin
                    o_cmd.flg_upd = 1'b1;
                    n_state       = ST_TCHK;
                end
            end
            ST_TCHK: begin
                if (i_sts.in_tri) begin
                    n_state = ST_NEXT;
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = ST_TEST;
                end
            end
            // emit the ear, then close the gap in the list
            ST_EAR: begin
                o_cmd.produce = i_sts.prod_ok;
                if (i_sts.prod_ok) begin
                    n_k     = r_i;
                    n_state = ST_MOVE;
                end
            end
            ST_MOVE: begin
                if ((r_k + CNT_W'(1)) >= r_cnt) begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = ST_PASS;
                end else begin
                    o_cmd.rem_raddr = IDX_W'(r_k + CNT_W'(1));
                    n_state         = ST_MOVE_W;
                end
            end
            ST_MOVE_W: begin
                o_cmd.rem_we      = 1'b1;
                o_cmd.rem_waddr   = r_k[IDX_W-1:0];
                o_cmd.rem_wsel_rd = 1'b1;
                n_k               = r_k + CNT_W'(1);
                n_state           = ST_MOVE;
            end
            // last triangle of three remaining vertices
            ST_END: begin
                if (r_cnt == CNT_W'(MIN_POLY)) begin
                    n_faddr = IDX_W'(0); n_slot = SLOT_A; n_via = 1'b1;
                    n_ret = ST_END_B; n_state = ST_F_REM;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_END_B: begin
                n_faddr = IDX_W'(1); n_slot = SLOT_B; n_via = 1'b1;
                n_ret = ST_END_C; n_state = ST_F_REM;
            end
            ST_END_C: begin
                n_faddr = IDX_W'(2); n_slot = SLOT_C; n_via = 1'b1;
                n_ret = ST_END_P; n_state = ST_F_REM;
            end
            ST_END_P: begin
                o_cmd.produce = i_sts.prod_ok;
                if (i_sts.prod_ok) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.pend_valid) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_i     = CNT_W'(1);
                    n_state = ST_FAN;
                end
            end
            // fan fallback from vertex zero
            ST_FAN: begin
                o_cmd.produce     = i_sts.prod_ok;
                o_cmd.prod_imm    = 1'b1;
                o_cmd.tri_imm.b   = r_i[IDX_W-1:0];
                o_cmd.tri_imm.c   = w_inext[IDX_W-1:0];
                o_cmd.tri_imm.has = 1'b1;
                o_cmd.tri_imm.fb  = 1'b1;
                if (i_sts.prod_ok) begin
                    if ((w_inext + CNT_W'(1)) == r_vcnt) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_i = w_inext;
                    end
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_vcnt  = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = '0;
                    n_att   = '0;
                    n_state = ST_IDLE;
                end
            end
            // vertex fetch: list read, coordinate read, slot capture
            ST_F_REM: begin
                n_state = ST_F_CRD;
            end
            ST_F_CRD: begin
                n_state = ST_F_CAP;
            end
            ST_F_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = r_ret;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_sts.pend_valid)
        else $error("pending result left at idle");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(MAX_VERTICES)) && (r_vcnt <= CNT_W'(MAX_VERTICES)))
        else $error("vertex count out of range");
    a_fan_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FAN) |-> (r_vcnt >= CNT_W'(MIN_POLY)))
        else $error("fan fallback on a short polygon");

endmodule

`default_nettype wire

FILE: design/polygon_ear_clip_triangulator.sv
// Top level of the polygon ear-clip triangulator.
//
//  channel | direction | payload
//  s       | in        | tdata = vertex_x[15:0], vertex_y[31:16]; tlast = last_vertex
//  m       | out       | tdata = corner_a, corner_b, corner_c; tuser = has, fallback, ovf;
//          |           | tlast = last_triangle
//  cfg     | in        | wdata = convex_threshold
//
// A vertex that is not last is stored as it is taken. The last vertex starts triangulation, and
// no new request is taken until its final triangle has been loaded into the output register.
// All geometry goes through one shared cross-product unit fed by vertex and index stores
// with one registered read port each: the signed area, the convexity check of each corner
// tried and the test of each point against a corner all run through it in turn.
// Reset is synchronous, active low; the stores need no clearing.
// Output stalls hold the controller only when a new triangle has nowhere to go.
`default_nettype none

module polygon_ear_clip_triangulator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [ecl_pkg::S_TDATA_W-1:0]   i_s_tdata,  // vertex_x, vertex_y
    input  wire logic                            i_s_tlast,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [ecl_pkg::M_TDATA_W-1:0]        o_m_tdata,  // corner_a, corner_b, corner_c
    output logic [ecl_pkg::M_TUSER_W-1:0]        o_m_tuser,  // has_triangle, used_fallback, overflowed
    output logic                                 o_m_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [ecl_pkg::THR_W-1:0]       i_cfg_wdata
);
    import ecl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_tri w_tri;

    ecl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_last  (i_s_tlast),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ecl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_vx        (i_s_tdata[COORD_BITS-1:0]),
        .i_vy        (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_valid   (o_m_tvalid),
        .i_m_ready   (i_m_tready),
        .o_m_tri     (w_tri),
        .o_m_last    (o_m_tlast)
    );

    // result packing
    assign o_m_tdata = {{(M_TDATA_W-M_TRI_W){1'b0}}, w_tri.c, w_tri.b, w_tri.a};
    assign o_m_tuser = {w_tri.ovf, w_tri.fb, w_tri.has};

endmodule

`default_nettype wire
